// ===== rtl/tssf_pkg.sv =====
// Shared constants, types and helpers for the toggle speaker sample FIFO.
package tssf_pkg;

  localparam int RING_DEPTH  = 2048;
  localparam int RING_AW     = $clog2(RING_DEPTH);
  localparam int LEVEL_W     = $clog2(RING_DEPTH + 1);
  localparam int ACC_W       = 17;
  localparam int PERIOD_W    = 16;
  localparam int VOL_W       = 8;
  localparam int CYCLE_W     = 8;
  localparam int SAMPLE_W    = 8;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [ACC_W-1:0]    ACC_MAX      = {ACC_W{1'b1}};
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd46;
  localparam logic [VOL_W-1:0]    VOL_RESET    = 8'd128;

  typedef enum logic [1:0] {
    CMD_TOGGLE  = 2'd0,
    CMD_ADVANCE = 2'd1,
    CMD_PULL    = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_PERIOD = 1'b0,
    REG_VOLUME        = 1'b1
  } reg_idx_t;

  // What the front end decided for one item
  typedef struct packed {
    logic               is_pull;
    logic               fresh;
    logic               ovf;
    logic [LEVEL_W-1:0] level;
  } front_rec_t;

  // Front decision plus the ring bit read for it
  typedef struct packed {
    front_rec_t rec;
    logic       ring_bit;
  } back_rec_t;

  // Level on maps to +127, off to -128, times vol/256, truncated toward zero
  function automatic logic [SAMPLE_W-1:0] scale_level(input logic on,
                                                      input logic [VOL_W-1:0] vol);
    logic [VOL_W+6:0] prod;
    prod = {vol, 7'b0} - {7'b0, vol};
    if (on) begin
      scale_level = {1'b0, prod[VOL_W+6:8]};
    end else begin
      scale_level = 8'd0 - {1'b0, vol[VOL_W-1:1]};
    end
  endfunction

endpackage

// ===== rtl/toggle_speaker_sample_fifo_core.sv =====
// Top level of the toggle speaker sample FIFO.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  in_command, in_cycle_count
//   out      output     out_valid/out_stall  out_sample_out, out_sample_fresh,
//                                            out_overflow, out_fifo_level
//   cfg      input      cfg_we               cfg_index, cfg_data
//
// One item per cycle sustained while in_stall is low; an accepted item updates the
// front state and reads the ring, is then written into the queue, and then loads
// the output register, where out_stall can hold it.
// The ring lives in a 1-bit RAM with one write and one registered read port.
// Reset is synchronous; the ring contents are not cleared, no clearing pass.
// in_stall rises when the queue plus the item in the read stage hold three items.
module toggle_speaker_sample_fifo_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [1:0]                            in_command,
  input  logic [tssf_pkg::CYCLE_W-1:0]          in_cycle_count,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [tssf_pkg::SAMPLE_W-1:0]  out_sample_out,
  output logic                                  out_sample_fresh,
  output logic                                  out_overflow,
  output logic [tssf_pkg::LEVEL_W-1:0]          out_fifo_level,
  input  logic                                  cfg_we,
  input  logic [tssf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tssf_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int QCW = tssf_pkg::QUEUE_CW;
  localparam logic [QCW:0] STALL_AT = (QCW+1)'(tssf_pkg::QUEUE_DEPTH - 1);

  logic [tssf_pkg::PERIOD_W-1:0] period_r;
  logic [tssf_pkg::VOL_W-1:0]    volume_r;

  logic                          accept;
  logic                          ram_we, ram_re, ram_wdata, ram_rdata;
  logic [tssf_pkg::RING_AW-1:0]  ram_waddr, ram_raddr;
  logic                          rec_valid;
  tssf_pkg::front_rec_t          rec;
  tssf_pkg::back_rec_t           q_in, q_out;
  logic                          q_pop, q_not_empty;
  logic [QCW-1:0]                q_count;
  logic [tssf_pkg::SAMPLE_W-1:0] sample;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= tssf_pkg::PERIOD_RESET;
      volume_r <= tssf_pkg::VOL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tssf_pkg::REG_SAMPLE_PERIOD: period_r <= cfg_data[tssf_pkg::PERIOD_W-1:0];
        tssf_pkg::REG_VOLUME:        volume_r <= cfg_data[tssf_pkg::VOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Leave room for the item in the RAM read stage
  assign in_stall = ({1'b0, q_count} + (QCW+1)'(rec_valid)) >= STALL_AT;
  assign accept   = in_valid && !in_stall;

  tssf_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .command       (in_command),
    .cycle_count   (in_cycle_count),
    .sample_period (period_r),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_re        (ram_re),
    .ram_raddr     (ram_raddr),
    .rec_valid     (rec_valid),
    .rec           (rec)
  );

  tssf_ram #(
    .WIDTH (1),
    .DEPTH (tssf_pkg::RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign q_in.rec      = rec;
  assign q_in.ring_bit = ram_rdata;

  tssf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (rec_valid),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .not_empty (q_not_empty),
    .count     (q_count)
  );

  tssf_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .volume_fraction (volume_r),
    .q_not_empty     (q_not_empty),
    .q_data          (q_out),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_sample      (sample),
    .out_fresh       (out_sample_fresh),
    .out_ovf         (out_overflow),
    .out_level       (out_fifo_level)
  );

  assign out_sample_out = $signed(sample);

endmodule

// ===== rtl/tssf_ram.sv =====
// Generic simple dual-port RAM with registered read.
module tssf_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/tssf_front.sv =====
// Front end: speaker level, cycle accumulator, ring pointers and fill count.
module tssf_front (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   accept,
  input  logic [1:0]                             command,
  input  logic [tssf_pkg::CYCLE_W-1:0]           cycle_count,
  input  logic [tssf_pkg::PERIOD_W-1:0]          sample_period,
  output logic                                   ram_we,
  output logic [tssf_pkg::RING_AW-1:0]           ram_waddr,
  output logic                                   ram_wdata,
  output logic                                   ram_re,
  output logic [tssf_pkg::RING_AW-1:0]           ram_raddr,
  output logic                                   rec_valid,
  output tssf_pkg::front_rec_t                   rec
);

  localparam int AW = tssf_pkg::RING_AW;
  localparam int LW = tssf_pkg::LEVEL_W;
  localparam int CW = tssf_pkg::ACC_W;

  localparam logic [AW-1:0] LAST_IDX   = AW'(tssf_pkg::RING_DEPTH - 1);
  localparam logic [LW-1:0] FULL_LEVEL = LW'(tssf_pkg::RING_DEPTH);

  logic                 speaker_r, speaker_nxt;
  logic [CW-1:0]        acc_r, acc_nxt;
  logic [AW-1:0]        wptr_r, wptr_nxt;
  logic [AW-1:0]        rptr_r, rptr_nxt;
  logic [LW-1:0]        count_r, count_nxt;
  logic                 rec_valid_r;
  tssf_pkg::front_rec_t rec_r, rec_nxt;

  logic          is_toggle, is_advance, is_pull;
  logic [CW:0]   sum;
  logic [CW-1:0] sat;
  logic [CW-1:0] period_ext;
  logic          due, full, push, pop;

  always_comb begin
    is_toggle  = (command == tssf_pkg::CMD_TOGGLE);
    is_advance = (command == tssf_pkg::CMD_ADVANCE);
    is_pull    = (command == tssf_pkg::CMD_PULL);

    sum        = {1'b0, acc_r} + (CW+1)'(cycle_count);
    sat        = sum[CW] ? tssf_pkg::ACC_MAX : sum[CW-1:0];
    period_ext = CW'(sample_period);
    due        = is_advance && (sat >= period_ext);
    full       = (count_r == FULL_LEVEL);
    push       = due && !full;
    pop        = is_pull && (count_r != '0);

    speaker_nxt = is_toggle ? ~speaker_r : speaker_r;
    acc_nxt     = acc_r;
    if (is_advance) begin
      acc_nxt = due ? (sat - period_ext) : sat;
    end
    wptr_nxt = wptr_r;
    if (push) begin
      wptr_nxt = (wptr_r == LAST_IDX) ? '0 : wptr_r + AW'(1);
    end
    rptr_nxt = rptr_r;
    if (pop) begin
      rptr_nxt = (rptr_r == LAST_IDX) ? '0 : rptr_r + AW'(1);
    end
    count_nxt = count_r;
    if (push) begin
      count_nxt = count_r + LW'(1);
    end else if (pop) begin
      count_nxt = count_r - LW'(1);
    end

    rec_nxt.is_pull = is_pull;
    rec_nxt.fresh   = pop;
    rec_nxt.ovf     = due && full;
    rec_nxt.level   = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speaker_r   <= 1'b0;
      acc_r       <= '0;
      wptr_r      <= '0;
      rptr_r      <= '0;
      count_r     <= '0;
      rec_valid_r <= 1'b0;
    end else begin
      rec_valid_r <= accept;
      if (accept) begin
        speaker_r <= speaker_nxt;
        acc_r     <= acc_nxt;
        wptr_r    <= wptr_nxt;
        rptr_r    <= rptr_nxt;
        count_r   <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rec_r <= rec_nxt;
    end
  end

  assign ram_we    = accept && push;
  assign ram_waddr = wptr_r;
  assign ram_wdata = speaker_r;
  assign ram_re    = accept && pop;
  assign ram_raddr = rptr_r;
  assign rec_valid = rec_valid_r;
  assign rec       = rec_r;

endmodule

// ===== rtl/tssf_queue.sv =====
// Short queue of decided items between front end and back end.
module tssf_queue (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  input  tssf_pkg::back_rec_t                 push_data,
  input  logic                                pop,
  output tssf_pkg::back_rec_t                 pop_data,
  output logic                                not_empty,
  output logic [tssf_pkg::QUEUE_CW-1:0]       count
);

  localparam int AW = tssf_pkg::QUEUE_AW;
  localparam int CW = tssf_pkg::QUEUE_CW;

  localparam logic [AW-1:0] LAST_IDX = AW'(tssf_pkg::QUEUE_DEPTH - 1);

  tssf_pkg::back_rec_t entry_r [tssf_pkg::QUEUE_DEPTH];
  logic [AW-1:0]       wptr_r, wptr_nxt;
  logic [AW-1:0]       rptr_r, rptr_nxt;
  logic [CW-1:0]       count_r, count_nxt;

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push) begin
      wptr_nxt = (wptr_r == LAST_IDX) ? '0 : wptr_r + AW'(1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == LAST_IDX) ? '0 : rptr_r + AW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wptr_r] <= push_data;
    end
  end

  assign pop_data  = entry_r[rptr_r];
  assign not_empty = (count_r != '0);
  assign count     = count_r;

endmodule

// ===== rtl/tssf_back.sv =====
// Back end: sample scaling, held last sample and output register.
module tssf_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [tssf_pkg::VOL_W-1:0]         volume_fraction,
  input  logic                               q_not_empty,
  input  tssf_pkg::back_rec_t                q_data,
  output logic                               q_pop,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [tssf_pkg::SAMPLE_W-1:0]      out_sample,
  output logic                               out_fresh,
  output logic                               out_ovf,
  output logic [tssf_pkg::LEVEL_W-1:0]       out_level
);

  logic                            valid_r;
  logic [tssf_pkg::SAMPLE_W-1:0]   last_r, last_nxt;
  logic [tssf_pkg::SAMPLE_W-1:0]   sample_r, sample_nxt;
  logic                            fresh_r, ovf_r;
  logic [tssf_pkg::LEVEL_W-1:0]    level_r;
  logic                            load;

  assign load = q_not_empty && (!valid_r || !out_stall);

  always_comb begin
    last_nxt = last_r;
    if (q_data.rec.fresh) begin
      last_nxt = tssf_pkg::scale_level(q_data.ring_bit, volume_fraction);
    end
    sample_nxt = q_data.rec.is_pull ? last_nxt : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      last_r  <= '0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        last_r  <= last_nxt;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  // Hold the payload while stalled
  always_ff @(posedge clk) begin
    if (load) begin
      sample_r <= sample_nxt;
      fresh_r  <= q_data.rec.fresh;
      ovf_r    <= q_data.rec.ovf;
      level_r  <= q_data.rec.level;
    end
  end

  assign q_pop      = load;
  assign out_valid  = valid_r;
  assign out_sample = sample_r;
  assign out_fresh  = fresh_r;
  assign out_ovf    = ovf_r;
  assign out_level  = level_r;

endmodule

// ===== rtl/tssf_checker.sv =====
// Port-level checker for the toggle speaker sample FIFO, bound to the top.
module tssf_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic                                  out_sample_fresh,
  input logic                                  out_overflow,
  input logic [tssf_pkg::LEVEL_W-1:0]          out_fifo_level
);

  localparam logic [tssf_pkg::LEVEL_W-1:0] FULL_LEVEL =
    tssf_pkg::LEVEL_W'(tssf_pkg::RING_DEPTH);

  // No result right after reset
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  // Overflow only when the ring is full
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> out_fifo_level == FULL_LEVEL)
    else $error("overflow with ring not full");

  // A popped sample leaves room in the ring and is not an overflow
  a_fresh_room: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sample_fresh |-> out_fifo_level != FULL_LEVEL && !out_overflow)
    else $error("fresh sample with full ring");

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_fifo_level <= FULL_LEVEL)
    else $error("fill level beyond ring depth");

endmodule

bind toggle_speaker_sample_fifo_core tssf_checker u_tssf_checker (.*);
